@@ rtl/rdc_pkg.sv @@
// radial dead zone clamp: shared types and constants
// no dependencies
package rdc_pkg;

	// pipeline depth: squares, 8 root stages, classify, 8 divide stages, output
	localparam int NSTG = 19;
	localparam int SQRT_FIRST = 1;
	localparam int SQRT_LAST = 8;
	localparam int CLASS_STG = 9;
	localparam int DIV_FIRST = 10;
	localparam int DIV_LAST = 17;
	localparam int OUT_STG = 18;

	typedef enum logic [1:0] {
		ZONE_DEAD = 2'd0,
		ZONE_PASS = 2'd1,
		ZONE_CLAMP = 2'd2
	} zone_t;

	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_MIN_RADIUS = 2'd2,
		REG_MAX_RADIUS = 2'd3
	} reg_idx_t;

	// one pipeline word
	typedef struct packed {
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic [31:0] n;
		logic [17:0] rem;
		logic [15:0] root;
		zone_t zone;
		logic negx;
		logic negy;
		logic [31:0] numx;
		logic [31:0] numy;
		logic [16:0] remx;
		logic [16:0] remy;
		logic [15:0] qx;
		logic [15:0] qy;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic sat;
	} stage_t;

endpackage

@@ rtl/rdc_if.sv @@
// radial dead zone clamp: input and result channel interfaces
// depends on nothing
interface rdc_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] dx;
	logic signed [15:0] dy;
	modport source (output valid, output dx, output dy, input ready);
	modport sink (input valid, input dx, input dy, output ready);
endinterface

interface rdc_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [1:0] zone;
	logic saturated;
	modport source (output valid, output pos_x, output pos_y, output zone,
		output saturated, input ready);
	modport sink (input valid, input pos_x, input pos_y, input zone,
		input saturated, output ready);
endinterface

@@ rtl/radial_deadzone_clamp_top.sv @@
// radial dead zone clamp top level
// depends on rdc_pkg and the channel interfaces in rdc_if.sv
//
// usage: displacement words (dx, dy) enter on the stick channel, one word per
// cycle while stick.ready is high. each word passes 19 register stages before
// its result word shows on the result channel.
// throughput is one word per cycle when the receiver does not stall.
// the length is a floor square root taken two bits per stage over 8 stages;
// the clamp scaling is a restoring divide, two quotient bits per stage over
// 8 stages, one unit for x and one for y.
// configuration (centre, min and max radius) is written on the cfg port while
// the pipeline is empty.
// reset clears all valid bits and loads centre 0, min radius 0, max 65535.
// when the receiver stalls, each stage holds only if the stage after it holds;
// empty stages keep filling, so input stays ready until the pipe is full.
module radial_deadzone_clamp_top
	import rdc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [15:0] cfg_data,
	rdc_in_if.sink stick,
	rdc_out_if.source result
);

	logic signed [15:0] center_x_q;
	logic signed [15:0] center_y_q;
	logic [15:0] min_radius_q;
	logic [15:0] max_radius_q;

	stage_t pipe_s [NSTG];
	stage_t nxt [NSTG];
	logic [NSTG-1:0] v_s;
	logic [NSTG:0] ce;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			min_radius_q <= '0;
			max_radius_q <= 16'hffff;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				REG_MIN_RADIUS: min_radius_q <= cfg_data;
				REG_MAX_RADIUS: max_radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables: a stage moves if empty or the next one moves
	always_comb begin
		ce[NSTG] = result.ready;
		for (int k = NSTG - 1; k >= 0; k--) begin
			ce[k] = !v_s[k] || ce[k+1];
		end
	end

	assign stick.ready = ce[0];

	// next-stage logic
	always_comb begin
		stage_t p;
		logic [19:0] r;
		logic [17:0] t;
		logic [16:0] dr;
		logic [15:0] ln;
		logic signed [17:0] sx;
		logic signed [17:0] sy;
		logic signed [16:0] ox;
		logic signed [16:0] oy;
		for (int k = 0; k < NSTG; k++) begin
			p = (k == 0) ? '0 : pipe_s[(k == 0) ? 0 : k - 1];
			if (k == 0) begin
				// squares of the displacement
				p.dx = stick.dx;
				p.dy = stick.dy;
				p.n = 32'(32'(stick.dx * stick.dx) + 32'(stick.dy * stick.dy));
				p.rem = '0;
				p.root = '0;
			end else if (k >= SQRT_FIRST && k <= SQRT_LAST) begin
				// two root bits per stage
				for (int j = 0; j < 2; j++) begin
					r = {p.rem, p.n[31:30]};
					t = {p.root, 2'b01};
					p.n = {p.n[29:0], 2'b00};
					if (r >= 20'(t)) begin
						p.rem = 18'(r - 20'(t));
						p.root = {p.root[14:0], 1'b1};
					end else begin
						p.rem = r[17:0];
						p.root = {p.root[14:0], 1'b0};
					end
				end
			end else if (k == CLASS_STG) begin
				// pick the zone and form the clamp numerators
				// (magnitude of -32768 reads as 32768 when taken unsigned)
				ln = p.root;
				if (ln <= min_radius_q) p.zone = ZONE_DEAD;
				else if (ln >= max_radius_q) p.zone = ZONE_CLAMP;
				else p.zone = ZONE_PASS;
				p.negx = p.dx[15];
				p.negy = p.dy[15];
				p.numx = 32'(16'(p.dx[15] ? -p.dx : p.dx) * max_radius_q);
				p.numy = 32'(16'(p.dy[15] ? -p.dy : p.dy) * max_radius_q);
			end else if (k >= DIV_FIRST && k <= DIV_LAST) begin
				// two quotient bits per stage for each axis
				if (k == DIV_FIRST) begin
					p.remx = {1'b0, p.numx[31:16]};
					p.remy = {1'b0, p.numy[31:16]};
					p.numx = {p.numx[15:0], 16'h0000};
					p.numy = {p.numy[15:0], 16'h0000};
					p.qx = '0;
					p.qy = '0;
				end
				for (int j = 0; j < 2; j++) begin
					dr = {p.remx[15:0], p.numx[31]};
					p.numx = {p.numx[30:0], 1'b0};
					if (dr >= {1'b0, p.root}) begin
						p.remx = dr - {1'b0, p.root};
						p.qx = {p.qx[14:0], 1'b1};
					end else begin
						p.remx = dr;
						p.qx = {p.qx[14:0], 1'b0};
					end
					dr = {p.remy[15:0], p.numy[31]};
					p.numy = {p.numy[30:0], 1'b0};
					if (dr >= {1'b0, p.root}) begin
						p.remy = dr - {1'b0, p.root};
						p.qy = {p.qy[14:0], 1'b1};
					end else begin
						p.remy = dr;
						p.qy = {p.qy[14:0], 1'b0};
					end
				end
			end else begin
				// add the centre and saturate; a dead zone word takes the centre itself
				if (p.zone == ZONE_CLAMP) begin
					ox = p.negx ? -$signed({1'b0, p.qx}) : $signed({1'b0, p.qx});
					oy = p.negy ? -$signed({1'b0, p.qy}) : $signed({1'b0, p.qy});
				end else begin
					ox = 17'(p.dx);
					oy = 17'(p.dy);
				end
				sx = 18'(center_x_q) + 18'(ox);
				sy = 18'(center_y_q) + 18'(oy);
				p.sat = 1'b0;
				if (p.zone == ZONE_DEAD) begin
					p.px = center_x_q;
					p.py = center_y_q;
				end else begin
					if (sx > 18'sd32767) begin
						p.px = 16'sh7fff;
						p.sat = 1'b1;
					end else if (sx < -18'sd32768) begin
						p.px = 16'sh8000;
						p.sat = 1'b1;
					end else begin
						p.px = sx[15:0];
					end
					if (sy > 18'sd32767) begin
						p.py = 16'sh7fff;
						p.sat = 1'b1;
					end else if (sy < -18'sd32768) begin
						p.py = 16'sh8000;
						p.sat = 1'b1;
					end else begin
						p.py = sy[15:0];
					end
				end
			end
			nxt[k] = p;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int k = 0; k < NSTG; k++) begin
				if (ce[k]) v_s[k] <= (k == 0) ? stick.valid : v_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	// pipeline words
	always_ff @(posedge clk) begin
		for (int k = 0; k < NSTG; k++) begin
			if (ce[k]) pipe_s[k] <= nxt[k];
		end
	end

	assign result.valid = v_s[OUT_STG];
	assign result.pos_x = pipe_s[OUT_STG].px;
	assign result.pos_y = pipe_s[OUT_STG].py;
	assign result.zone = pipe_s[OUT_STG].zone;
	assign result.saturated = pipe_s[OUT_STG].sat;

endmodule

@@ rtl/rdc_checker.sv @@
// radial dead zone clamp: port checker and its bind to the top level
// depends on rdc_pkg
module rdc_checker
	import rdc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] out_zone,
	input logic out_sat
);

	// a waiting word stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result word dropped");

	// a draining output never blocks input
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready) else $error("input stalled while output drains");

	// zone code three never appears
	a_zone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_zone != 2'd3) else $error("bad zone code");

	// a dead zone word is never flagged saturated
	a_dead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_zone == ZONE_DEAD |-> !out_sat) else $error("dead zone saturated");

endmodule

bind radial_deadzone_clamp_top rdc_checker u_rdc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(stick.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_zone(result.zone),
	.out_sat(result.saturated)
);
